// ----- hdl/nearest_value_request_scheduler_macros.svh -----
`ifndef NEAREST_VALUE_REQUEST_SCHEDULER_MACROS_SVH
`define NEAREST_VALUE_REQUEST_SCHEDULER_MACROS_SVH

// same-cycle implication
`define NVRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NVRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/nvrs_pkg.sv -----
`timescale 1ns / 1ps

package nvrs_pkg;

	localparam int REQ_W       = 4;
	localparam int VAL_W       = 10;
	localparam int GAP_W       = 11;
	localparam int KEY_W       = 11;
	localparam int ACT_W       = 5;
	localparam int CAP_W       = 4;
	localparam int RES_CNT_W   = 4;
	localparam int MAX_RESULTS = 8;
	localparam int TDATA_W     = 16;
	localparam int PAD_W       = TDATA_W - REQ_W - VAL_W;
	localparam int CFG_DATA_W  = 5;
	localparam int REQ_ID_SPACE = 2 ** REQ_W;

	localparam int BOARD_SLOTS_DEF     = 8;
	localparam int REQUESTER_COUNT_DEF = 16;

	localparam logic [CAP_W-1:0]        CAP_RESET       = 4'd8;
	localparam logic [ACT_W-1:0]        REQ_TOTAL_RESET = 5'd16;
	localparam logic signed [KEY_W-1:0] KEY_RESET       = -11'sd1;

	typedef enum logic {
		OP_POST   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_SERVED = 2'd0,
		ST_BUSY   = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic {
		REG_CAPACITY  = 1'b0,
		REG_REQ_TOTAL = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN
	} state_t;

	// running best of the nearest-value search, passed cell to cell
	typedef struct packed {
		logic              found;
		logic [GAP_W-1:0]  gap;
		logic [REQ_W-1:0]  owner;
		logic [VAL_W-1:0]  value;
	} tok_t;

	// broadcast to all cells: owner query, insert payload, remove by owner
	typedef struct packed {
		logic             take;
		logic [REQ_W-1:0] owner;
		logic [VAL_W-1:0] value;
	} bcast_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} cell_sts_t;

	typedef struct packed {
		logic hit;
		logic no_free;
	} board_t;

	typedef struct packed {
		status_t          status;
		logic [REQ_W-1:0] requester;
		logic [VAL_W-1:0] value;
	} res_t;

endpackage

// ----- hdl/nearest_value_request_scheduler.sv -----
`timescale 1ns / 1ps
// Accepts a request, decides post or finish on acceptance, then checks for due serves.
// Each serve lets the best-so-far ripple down the registered cell chain and then pushes
// the result into the pending buffer; serves repeat while more are due.
// Up to 8 results per request; one request in flight at a time, results buffered one deep.
// Reset (arst_n low) empties the board, clears finish flags, sets capacity 8,
// active count min(16, REQUESTER_COUNT) and last served value to -1. No clearing pass.

module nearest_value_request_scheduler #(
	parameter int BOARD_SLOTS     = nvrs_pkg::BOARD_SLOTS_DEF,
	parameter int REQUESTER_COUNT = nvrs_pkg::REQUESTER_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nvrs_pkg::TDATA_W-1:0]    s_tdata,   // requester[3:0], request_value[13:4]
	input  logic                            s_tuser,   // operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nvrs_pkg::TDATA_W-1:0]    m_tdata,   // served_requester[3:0], served_value[13:4]
	output logic [1:0]                      m_tuser,   // status
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [nvrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(BOARD_SLOTS + 1);

	nvrs_pkg::tok_t                     tok [BOARD_SLOTS+1];
	nvrs_pkg::cell_sts_t                sts [BOARD_SLOTS];
	nvrs_pkg::bcast_t                   bc;
	nvrs_pkg::board_t                   board;
	logic                               ins;
	logic [CNT_W-1:0]                   cap_eff;
	logic signed [nvrs_pkg::KEY_W-1:0]  key;
	logic [BOARD_SLOTS-1:0]             ins_oh;
	logic [BOARD_SLOTS-1:0]             hit_v;
	logic                               free_seen;

	assign tok[0] = '0;

	// lowest free slot below the capacity
	always_comb begin
		ins_oh    = '0;
		free_seen = 1'b0;
		for (int i = 0; i < BOARD_SLOTS; i++) begin
			hit_v[i] = sts[i].hit;
			if (!free_seen && !sts[i].valid && (i < int'(cap_eff))) begin
				ins_oh[i] = 1'b1;
				free_seen = 1'b1;
			end
		end
	end

	assign board.hit     = |hit_v;
	assign board.no_free = ~|ins_oh;

	nvrs_ctrl #(
		.BOARD_SLOTS     (BOARD_SLOTS),
		.REQUESTER_COUNT (REQUESTER_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.board     (board),
		.tok_end   (tok[BOARD_SLOTS]),
		.bc        (bc),
		.ins       (ins),
		.cap_eff   (cap_eff),
		.key       (key)
	);

	for (genvar g = 0; g < BOARD_SLOTS; g++) begin : g_cell
		nvrs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.key    (key),
			.bc     (bc),
			.ins    (ins && ins_oh[g]),
			.tok_i  (tok[g]),
			.tok_o  (tok[g+1]),
			.sts    (sts[g])
		);
	end

endmodule

// ----- hdl/nvrs_cell.sv -----
`timescale 1ns / 1ps

module nvrs_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [nvrs_pkg::KEY_W-1:0]  key,
	input  nvrs_pkg::bcast_t                   bc,
	input  logic                               ins,
	input  nvrs_pkg::tok_t                     tok_i,
	output nvrs_pkg::tok_t                     tok_o,
	output nvrs_pkg::cell_sts_t                sts
);

	logic                               valid_q;
	logic [nvrs_pkg::VAL_W-1:0]         value_q;
	logic [nvrs_pkg::REQ_W-1:0]         owner_q;
	nvrs_pkg::tok_t                     tok_q;
	logic signed [nvrs_pkg::KEY_W:0]    diff;
	logic [nvrs_pkg::GAP_W-1:0]         gap;
	logic                               better;
	logic                               owner_eq;

	assign owner_eq = (owner_q == bc.owner);
	assign diff     = $signed({2'b00, value_q}) - $signed({key[nvrs_pkg::KEY_W-1], key});
	assign gap      = diff[nvrs_pkg::KEY_W] ? nvrs_pkg::GAP_W'(-diff)
	                                        : nvrs_pkg::GAP_W'(diff);
	// strict compare keeps the lower slot on a tie
	assign better   = valid_q && (!tok_i.found || (gap < tok_i.gap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			valid_q <= 1'b1;
		end else if (bc.take && valid_q && owner_eq) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			value_q <= bc.value;
			owner_q <= bc.owner;
		end
		if (better) begin
			tok_q.found <= 1'b1;
			tok_q.gap   <= gap;
			tok_q.owner <= owner_q;
			tok_q.value <= value_q;
		end else begin
			tok_q <= tok_i;
		end
	end

	assign tok_o     = tok_q;
	assign sts.valid = valid_q;
	assign sts.hit   = valid_q && owner_eq;

endmodule

// ----- hdl/nvrs_ctrl.sv -----
`timescale 1ns / 1ps

module nvrs_ctrl #(
	parameter int BOARD_SLOTS     = nvrs_pkg::BOARD_SLOTS_DEF,
	parameter int REQUESTER_COUNT = nvrs_pkg::REQUESTER_COUNT_DEF,
	localparam int CNT_W = $clog2(BOARD_SLOTS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nvrs_pkg::TDATA_W-1:0]        s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nvrs_pkg::TDATA_W-1:0]        m_tdata,
	output logic [1:0]                          m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [nvrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  nvrs_pkg::board_t                    board,
	input  nvrs_pkg::tok_t                      tok_end,
	output nvrs_pkg::bcast_t                    bc,
	output logic                                ins,
	output logic [CNT_W-1:0]                    cap_eff,
	output logic signed [nvrs_pkg::KEY_W-1:0]   key
);

	localparam int SCNT_W = (BOARD_SLOTS > 1) ? $clog2(BOARD_SLOTS) : 1;
	localparam int CW     = (CNT_W > nvrs_pkg::ACT_W) ? CNT_W : nvrs_pkg::ACT_W;
	localparam logic [nvrs_pkg::ACT_W-1:0] ACT_RESET =
		(REQUESTER_COUNT < int'(nvrs_pkg::REQ_TOTAL_RESET)) ?
		nvrs_pkg::ACT_W'(REQUESTER_COUNT) : nvrs_pkg::REQ_TOTAL_RESET;

	nvrs_pkg::state_t                       state_q, state_d;
	logic [nvrs_pkg::CAP_W-1:0]             cap_q, cap_d;
	logic [nvrs_pkg::ACT_W-1:0]             act_q, act_d, act_dec;
	logic [CNT_W-1:0]                       occ_q, occ_d;
	logic [nvrs_pkg::REQ_ID_SPACE-1:0]      fin_q, fin_d;
	logic signed [nvrs_pkg::KEY_W-1:0]      key_q, key_d;
	logic [nvrs_pkg::RES_CNT_W-1:0]         n_q, n_d;
	logic [SCNT_W-1:0]                      cnt_q, cnt_d;
	nvrs_pkg::res_t                         pend_q, pend_d;
	logic                                   pend_v_q, pend_v_d;
	nvrs_pkg::res_t                         out_q, out_d;
	logic                                   out_last_q, out_last_d;
	logic                                   out_v_q, out_v_d;

	logic                                   acc;
	logic                                   out_free;
	logic                                   due;
	logic                                   full;
	logic                                   req_known;
	logic                                   owner_known;
	logic [nvrs_pkg::REQ_W-1:0]             req;
	logic [nvrs_pkg::VAL_W-1:0]             val;
	logic [CW-1:0]                          act_x, cap_x, need_x;

	assign req = s_tdata[nvrs_pkg::REQ_W-1:0];
	assign val = s_tdata[nvrs_pkg::REQ_W+nvrs_pkg::VAL_W-1:nvrs_pkg::REQ_W];

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > BOARD_SLOTS) begin
			cap_eff = CNT_W'(BOARD_SLOTS);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	assign act_x   = CW'(act_q);
	assign cap_x   = CW'(cap_eff);
	assign need_x  = (act_x < cap_x) ? act_x : cap_x;
	assign due     = (n_q < nvrs_pkg::RES_CNT_W'(nvrs_pkg::MAX_RESULTS)) && (act_q != '0) &&
	                 (occ_q != '0) && (CW'(occ_q) >= need_x);
	assign full    = (occ_q >= cap_eff) || board.no_free;
	assign act_dec = (act_q == '0) ? act_q : act_q - 1'b1;

	assign req_known   = int'(req) < REQUESTER_COUNT;
	assign owner_known = int'(tok_end.owner) < REQUESTER_COUNT;

	assign s_tready  = (state_q == nvrs_pkg::S_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign out_free  = !out_v_q || m_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d    = state_q;
		cap_d      = cap_q;
		act_d      = act_q;
		occ_d      = occ_q;
		fin_d      = fin_q;
		key_d      = key_q;
		n_d        = n_q;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		pend_v_d   = pend_v_q;
		out_d      = out_q;
		out_last_d = out_last_q;
		out_v_d    = out_v_q && !m_tready;
		ins        = 1'b0;
		bc.take    = 1'b0;
		bc.owner   = req;
		bc.value   = val;

		case (state_q)
			nvrs_pkg::S_IDLE: begin
				if (acc) begin
					n_d     = '0;
					state_d = nvrs_pkg::S_CHECK;
					if (s_tuser == nvrs_pkg::OP_POST) begin
						if (full || board.hit) begin
							pend_d.status    = full ? nvrs_pkg::ST_FULL : nvrs_pkg::ST_BUSY;
							pend_d.requester = req;
							pend_d.value     = val;
							pend_v_d         = 1'b1;
							n_d              = nvrs_pkg::RES_CNT_W'(1);
						end else begin
							ins   = 1'b1;
							occ_d = occ_q + CNT_W'(1);
						end
					end else if (req_known && !fin_q[req]) begin
						fin_d[req] = 1'b1;
						if (!board.hit) begin
							act_d = act_dec;
						end
					end
				end
			end
			nvrs_pkg::S_CHECK: begin
				if (!pend_v_q || out_free) begin
					if (pend_v_q) begin
						out_d      = pend_q;
						out_last_d = !due;
						out_v_d    = 1'b1;
						pend_v_d   = 1'b0;
					end
					cnt_d   = '0;
					state_d = due ? nvrs_pkg::S_SCAN : nvrs_pkg::S_IDLE;
				end
			end
			nvrs_pkg::S_SCAN: begin
				bc.owner = tok_end.owner;
				if (cnt_q == SCNT_W'(BOARD_SLOTS - 1)) begin
					bc.take          = 1'b1;
					pend_d.status    = nvrs_pkg::ST_SERVED;
					pend_d.requester = tok_end.owner;
					pend_d.value     = tok_end.value;
					pend_v_d         = 1'b1;
					key_d            = $signed({1'b0, tok_end.value});
					occ_d            = occ_q - CNT_W'(1);
					n_d              = n_q + nvrs_pkg::RES_CNT_W'(1);
					if (owner_known && fin_q[tok_end.owner]) begin
						act_d = act_dec;
					end
					state_d = nvrs_pkg::S_CHECK;
				end else begin
					cnt_d = cnt_q + SCNT_W'(1);
				end
			end
			default: begin
				state_d = nvrs_pkg::S_IDLE;
			end
		endcase

		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nvrs_pkg::REG_CAPACITY: begin
					cap_d = cfg_data[nvrs_pkg::CAP_W-1:0];
				end
				nvrs_pkg::REG_REQ_TOTAL: begin
					act_d = (int'(cfg_data) > REQUESTER_COUNT) ?
					        nvrs_pkg::ACT_W'(REQUESTER_COUNT) : cfg_data[nvrs_pkg::ACT_W-1:0];
				end
				default: begin
					cap_d = cap_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nvrs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= nvrs_pkg::CAP_RESET;
			act_q    <= ACT_RESET;
			occ_q    <= '0;
			fin_q    <= '0;
			key_q    <= nvrs_pkg::KEY_RESET;
			n_q      <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			cap_q    <= cap_d;
			act_q    <= act_d;
			occ_q    <= occ_d;
			fin_q    <= fin_d;
			key_q    <= key_d;
			n_q      <= n_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			out_v_q  <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q     <= pend_d;
		out_q      <= out_d;
		out_last_q <= out_last_d;
	end

	assign key      = key_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{nvrs_pkg::PAD_W{1'b0}}, out_q.value, out_q.requester};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_last_q;

endmodule

// ----- hdl/nvrs_chk.sv -----
`timescale 1ns / 1ps
`include "nearest_value_request_scheduler_macros.svh"

module nvrs_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [nvrs_pkg::TDATA_W-1:0] m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         m_tlast
);

	`NVRS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`NVRS_ASSERT_NOW(a_run_open_busy, m_tvalid && !m_tlast, !s_tready, "ready before run end")
	`NVRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result moved")

endmodule

bind nearest_value_request_scheduler nvrs_chk u_chk (.*);
